[rtl/gn2d_pkg.sv]
// Package for the 2-D gradient noise unit: widths, hash constants, sine table.
package gn2d_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int COORD_W = 32;
    localparam int NOISE_W = 16;
    localparam int GRAD_W  = 17;   // signed Q1.15 gradient component

    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // quarter-wave sine in Q1.15 for m in [0, 2^(tb-2)], series form;
    // only evaluated while building the constant table
    function automatic logic [15:0] quarter_sine(input int unsigned m, input int tb);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned h;
        longint unsigned v;
        longint unsigned r;
        t  = (longint'(m) * HALF_PI_Q30) >> (tb - 2);
        t2 = (t * t) >> 30;
        h  = ONE_Q30;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 64'd110;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 64'd72;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 64'd42;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 64'd20;
        h  = ONE_Q30 - ((t2 * h) >> 30) / 64'd6;
        v = (t * h) >> 30;
        r = (v + (64'd1 << 14)) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

endpackage

[rtl/gradient_noise_2d_unit.sv]
// Top level of the 2-D gradient noise unit, a fully pipelined datapath.
// Pipeline: 12 register stages; m_valid is the valid bit of the last one.
// Throughput: one point per cycle; each stage holds one point and the whole
// pipe advances whenever the output register is empty or being taken.
// Reset: aresetn (synchronous, active low) clears all stage valid bits;
// payload registers are not reset.
module gradient_noise_2d_unit #(
    parameter int SINE_TABLE_BITS = gn2d_pkg::SINE_TABLE_BITS_DEF,
    parameter int FRACTION_BITS   = gn2d_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gn2d_pkg::COORD_W-1:0]  s_x_coord,
    input  logic signed [gn2d_pkg::COORD_W-1:0]  s_y_coord,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gn2d_pkg::NOISE_W-1:0]  m_noise_value
);
    import gn2d_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int TB  = SINE_TABLE_BITS;
    localparam int QB  = TB - 2;
    localparam int QN  = 1 << QB;
    localparam int OW  = F + 1;             // signed offset width
    localparam int WW  = F + 2;             // fade weight width (value <= 2^F)
    localparam int DW  = 48;                // dot/blend working width
    localparam int NST = 12;

    // quarter sine table, QN+1 entries, built at elaboration
    localparam int QTN = QN + 1;
    function automatic logic [16*QTN-1:0] build_sine_tab();
        logic [16*QTN-1:0] tab;
        tab = '0;
        for (int i = 0; i < QTN; i++) begin
            tab[16*i +: 16] = quarter_sine(i, TB);
        end
        return tab;
    endfunction
    localparam logic [16*QTN-1:0] SINE_TAB = build_sine_tab();

    logic [15:0] sine_rom [QTN];
    always_comb begin
        for (int i = 0; i < QTN; i++) begin
            sine_rom[i] = SINE_TAB[16*i +: 16];
        end
    end

    // pipeline enable: the whole pipe moves when the output slot frees up
    logic [NST-1:0] vld_reg;
    logic           adv;
    assign adv     = !vld_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // per-corner hash state: index 0..3 = (x0,y0),(x1,y0),(x0,y1),(x1,y1)
    // stage 1: split coordinates
    logic [31:0]   cx1_reg [4];
    logic [31:0]   cy1_reg [4];
    logic [F-1:0]  fx1_reg, fy1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [31:0] xi, yi;
            xi = {{F{s_x_coord[COORD_W-1]}}, s_x_coord[COORD_W-1:F]};
            yi = {{F{s_y_coord[COORD_W-1]}}, s_y_coord[COORD_W-1:F]};
            cx1_reg[0] <= xi;        cy1_reg[0] <= yi;
            cx1_reg[1] <= xi + 32'd1; cy1_reg[1] <= yi;
            cx1_reg[2] <= xi;        cy1_reg[2] <= yi + 32'd1;
            cx1_reg[3] <= xi + 32'd1; cy1_reg[3] <= yi + 32'd1;
            fx1_reg <= s_x_coord[F-1:0];
            fy1_reg <= s_y_coord[F-1:0];
        end
    end

    // fraction side-pipe carried down to the dot stage
    logic [F-1:0] fx_reg [2:5];
    logic [F-1:0] fy_reg [2:5];

    // stage 2: a *= A
    logic [31:0] a2_reg [4];
    logic [31:0] b2_reg [4];
    // stage 3: b ^= rot(a); b *= B
    logic [31:0] a3_reg [4];
    logic [31:0] b3_reg [4];
    // stage 4: a ^= rot(b); a *= C
    logic [31:0] a4_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                a2_reg[c] <= cx1_reg[c] * HASH_MUL_A;
                b2_reg[c] <= cy1_reg[c];
                a3_reg[c] <= a2_reg[c];
                b3_reg[c] <= (b2_reg[c] ^ rot16(a2_reg[c])) * HASH_MUL_B;
                a4_reg[c] <= (a3_reg[c] ^ rot16(b3_reg[c])) * HASH_MUL_C;
            end
            fx_reg[2] <= fx1_reg; fy_reg[2] <= fy1_reg;
            fx_reg[3] <= fx_reg[2]; fy_reg[3] <= fy_reg[2];
            fx_reg[4] <= fx_reg[3]; fy_reg[4] <= fy_reg[3];
            fx_reg[5] <= fx_reg[4]; fy_reg[5] <= fy_reg[4];
        end
    end

    // stage 5: table lookup and quadrant mapping to gradient
    logic signed [GRAD_W-1:0] gx5_reg [4];
    logic signed [GRAD_W-1:0] gy5_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                logic [TB-1:0] k;
                logic [1:0]    quad;
                logic [QB:0]   r, rc;
                logic signed [GRAD_W-1:0] sv, cv;
                k    = a4_reg[c][31 -: TB];
                quad = k[TB-1 -: 2];
                r    = {1'b0, k[QB-1:0]};
                rc   = (QB+1)'(QN) - r;
                sv   = $signed({1'b0, sine_rom[r]});
                cv   = $signed({1'b0, sine_rom[rc]});
                case (quad)
                    2'd0: begin gx5_reg[c] <= sv;  gy5_reg[c] <= cv;  end
                    2'd1: begin gx5_reg[c] <= cv;  gy5_reg[c] <= -sv; end
                    2'd2: begin gx5_reg[c] <= -sv; gy5_reg[c] <= -cv; end
                    default: begin gx5_reg[c] <= -cv; gy5_reg[c] <= sv; end
                endcase
            end
        end
    end

    // fade weights computed alongside the hash: s2 in stage 2..3, w in 4
    logic [2*F-1:0] s2p_reg [2];
    logic [F-1:0]   fxw_reg, fyw_reg;
    logic [WW-1:0]  wx_reg [4:7];
    logic [WW-1:0]  wy_reg [4:9];
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2p_reg[0] <= fx1_reg * fx1_reg;
            s2p_reg[1] <= fy1_reg * fy1_reg;
            fxw_reg <= fx1_reg;
            fyw_reg <= fy1_reg;
        end
    end
    logic [F+1:0] kx3_reg, ky3_reg;
    logic [F:0]   sx3_reg, sy3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            kx3_reg <= (F+2)'(3 << F) - (F+2)'({fxw_reg, 1'b0});
            ky3_reg <= (F+2)'(3 << F) - (F+2)'({fyw_reg, 1'b0});
            sx3_reg <= (F+1)'(s2p_reg[0] >> F);
            sy3_reg <= (F+1)'(s2p_reg[1] >> F);
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [2*F+2:0] px, py;
            px = kx3_reg * sx3_reg;
            py = ky3_reg * sy3_reg;
            wx_reg[4] <= WW'(px >> F);
            wy_reg[4] <= WW'(py >> F);
            for (int i = 5; i < 8; i++) begin
                wx_reg[i] <= wx_reg[i-1];
            end
            for (int i = 5; i < 10; i++) begin
                wy_reg[i] <= wy_reg[i-1];
            end
        end
    end

    // stage 6: the x and y partial products for each of the four corners
    logic signed [OW+GRAD_W-1:0] px6_reg [4];
    logic signed [OW+GRAD_W-1:0] py6_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [OW-1:0] dx0, dx1, dy0, dy1;
            dx0 = $signed({1'b0, fx_reg[5]});
            dy0 = $signed({1'b0, fy_reg[5]});
            dx1 = dx0 - $signed(OW'(1 << F));
            dy1 = dy0 - $signed(OW'(1 << F));
            px6_reg[0] <= dx0 * gx5_reg[0]; py6_reg[0] <= dy0 * gy5_reg[0];
            px6_reg[1] <= dx1 * gx5_reg[1]; py6_reg[1] <= dy0 * gy5_reg[1];
            px6_reg[2] <= dx0 * gx5_reg[2]; py6_reg[2] <= dy1 * gy5_reg[2];
            px6_reg[3] <= dx1 * gx5_reg[3]; py6_reg[3] <= dy1 * gy5_reg[3];
        end
    end

    // stage 7: dot sum scaled to Q30
    logic signed [DW-1:0] n7_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                logic signed [DW-1:0] d;
                d = DW'(px6_reg[c]) + DW'(py6_reg[c]);
                if (F >= 15) begin
                    n7_reg[c] <= d >>> (F - 15);
                end else begin
                    n7_reg[c] <= d <<< (15 - F);
                end
            end
        end
    end

    // stage 8: x-blend products; stage 9: add back
    logic signed [DW+WW:0] mx8_reg [2];
    logic signed [DW-1:0]  a8_reg  [2];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 2; j++) begin
                logic signed [DW:0] df;
                df = (DW+1)'(n7_reg[2*j+1]) - (DW+1)'(n7_reg[2*j]);
                mx8_reg[j] <= df * $signed({1'b0, wx_reg[7]});
                a8_reg[j]  <= n7_reg[2*j];
            end
        end
    end
    logic signed [DW-1:0] tb9_reg [2];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 2; j++) begin
                tb9_reg[j] <= a8_reg[j] + DW'(mx8_reg[j] >>> F);
            end
        end
    end

    // stage 10: y-blend product; stage 11: add back
    logic signed [DW+WW:0] my10_reg;
    logic signed [DW-1:0]  a10_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [DW:0] df;
            df = (DW+1)'(tb9_reg[1]) - (DW+1)'(tb9_reg[0]);
            my10_reg <= df * $signed({1'b0, wy_reg[9]});
            a10_reg  <= tb9_reg[0];
        end
    end
    logic signed [DW-1:0] v11_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            v11_reg <= a10_reg + DW'(my10_reg >>> F);
        end
    end

    // stage 12: round to Q2.14 and saturate into the output register
    logic signed [NOISE_W-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [DW-1:0] r;
            r = (v11_reg + DW'(1 << 15)) >>> 16;
            if (r > DW'(32767)) begin
                out_reg <= NOISE_W'(32767);
            end else if (r < -DW'(32768)) begin
                out_reg <= NOISE_W'(-32768);
            end else begin
                out_reg <= r[NOISE_W-1:0];
            end
        end
    end
    assign m_noise_value = out_reg;

endmodule
